/* rtl/byte_stack_with_value_swap_assert.svh */
// Assertion macros shared by the stack modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef BYTE_STACK_WITH_VALUE_SWAP_ASSERT_SVH
`define BYTE_STACK_WITH_VALUE_SWAP_ASSERT_SVH

// Check a condition at every edge outside reset.
`define BSVS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define BSVS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define BSVS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/bsvs_pkg.sv */
package bsvs_pkg;

   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 5;

   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SWAP = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;        // latch the request word
      logic                push;        // write value on top, bump count
      logic                pop;         // read top entry, drop count
      logic                scan_start;  // read bottom entry, clear match flags
      logic                scan_step;   // compare one entry, read the next
      logic                wr_first;    // write second value at first match
      logic                wr_second;   // write first value at second match
      logic                respond;     // load the response registers
      logic                pop_sel;     // response carries the read byte
      logic [STATUS_W-1:0] rsp_status;
   } bsvs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              empty;
      logic              full;
      logic              scan_last;   // entry under compare is the top one
      logic              hit_both;    // both values found, this entry included
   } bsvs_stat_type;

endpackage

/* rtl/byte_stack_with_value_swap.sv */
// Channel    Direction  Handshake              Payload
// request    in         start high, busy low   req_kind, req_value, req_second_value
// response   out        rsp_valid, one cycle   rsp_status, rsp_popped, rsp_depth
//
// From accept to the next accept: push, failed pop, swap on an empty stack and
// the unused kind respond from dispatch; a pop waits for its read; a swap scans
// and responds when a value is missing, else swaps. The scan walks the single
// memory read port one entry a cycle from the bottom and stops once both values
// are seen; the exchange uses the single write port in SWAP_WR1, then SWAP_WR2.
// Synchronous reset empties the stack; no clearing pass runs over storage.
// The response strobe lasts one cycle and cannot be stalled; busy is already
// low in that cycle, so the next word may be accepted there.
module byte_stack_with_value_swap #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bsvs_pkg::KIND_W-1:0]   req_kind,
   input  logic [bsvs_pkg::BYTE_W-1:0]   req_value,
   input  logic [bsvs_pkg::BYTE_W-1:0]   req_second_value,
   output logic                          rsp_valid,
   output logic [bsvs_pkg::STATUS_W-1:0] rsp_status,
   output logic [bsvs_pkg::BYTE_W-1:0]   rsp_popped,
   output logic [bsvs_pkg::DEPTH_W-1:0]  rsp_depth
);
   import bsvs_pkg::*;

   bsvs_cmd_type  cmd;
   bsvs_stat_type stat;

   // Sequence each word: decode, walk memory, write back, respond.
   bsvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the stack storage, fill count, scan state and response registers.
   bsvs_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .req_second_value (req_second_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_popped       (rsp_popped),
      .rsp_depth        (rsp_depth)
   );

endmodule

/* rtl/bsvs_dp.sv */
module bsvs_dp #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bsvs_pkg::KIND_W-1:0]     req_kind,
   input  logic [bsvs_pkg::BYTE_W-1:0]     req_value,
   input  logic [bsvs_pkg::BYTE_W-1:0]     req_second_value,
   input  bsvs_pkg::bsvs_cmd_type          cmd,
   output bsvs_pkg::bsvs_stat_type         stat,
   output logic [bsvs_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bsvs_pkg::BYTE_W-1:0]     rsp_popped,
   output logic [bsvs_pkg::DEPTH_W-1:0]    rsp_depth
);
   import bsvs_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [BYTE_W-1:0]   mem [STACK_DEPTH];
   logic [KIND_W-1:0]   kind_ff;
   logic [BYTE_W-1:0]   a_ff;
   logic [BYTE_W-1:0]   b_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff;
   logic [AW-1:0]       ia_ff;
   logic [AW-1:0]       ib_ff;
   logic                found_a_ff, found_b_ff;
   logic [BYTE_W-1:0]   rd_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [BYTE_W-1:0]   rsp_popped_ff;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic [BYTE_W-1:0]   wr_data;
   logic                wr_en;
   logic                match_a, match_b;

   assign match_a = (rd_ff == a_ff);
   assign match_b = (rd_ff == b_ff);

   always_comb begin
      stat.kind      = kind_ff;
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CW'(STACK_DEPTH));
      stat.scan_last = ((CW'(idx_ff) + CW'(1)) == count_ff);
      stat.hit_both  = (found_a_ff | match_a) & (found_b_ff | match_b);
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Single read port: top on pop, bottom on scan start, next entry on scan step.
   always_comb begin
      rd_addr = idx_ff;
      if (cmd.pop) begin
         rd_addr = AW'(count_ff - CW'(1));
      end else if (cmd.scan_start) begin
         rd_addr = '0;
      end else if (cmd.scan_step) begin
         rd_addr = idx_ff + AW'(1);
      end
   end

   // Single write port.
   always_comb begin
      wr_en   = cmd.push | cmd.wr_first | cmd.wr_second;
      wr_addr = AW'(count_ff);
      wr_data = a_ff;
      if (cmd.wr_first) begin
         wr_addr = ia_ff;
         wr_data = b_ff;
      end else if (cmd.wr_second) begin
         wr_addr = ib_ff;
         wr_data = a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         a_ff    <= req_value;
         b_ff    <= req_second_value;
      end
      if (cmd.scan_start) begin
         idx_ff <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + AW'(1);
         if (!found_a_ff && match_a) begin
            ia_ff <= idx_ff;
         end
         if (!found_b_ff && match_b) begin
            ib_ff <= idx_ff;
         end
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_popped_ff <= cmd.pop_sel ? rd_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         found_a_ff <= 1'b0;
         found_b_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.scan_start) begin
            found_a_ff <= 1'b0;
            found_b_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            found_a_ff <= found_a_ff | match_a;
            found_b_ff <= found_b_ff | match_b;
         end
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_popped = rsp_popped_ff;
   assign rsp_depth  = DEPTH_W'(count_ff);

`include "byte_stack_with_value_swap_assert.svh"

   `BSVS_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(STACK_DEPTH), "fill count past depth")
   `BSVS_ASSERT_IMPLY(a_push_room, cmd.push, !stat.full, "push issued on full stack")
   `BSVS_ASSERT_NEXT(a_pop_count, cmd.pop, count_ff == $past(count_ff) - CW'(1), "pop lost count")

endmodule

/* rtl/bsvs_ctrl.sv */
module bsvs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   input  bsvs_pkg::bsvs_stat_type stat,
   output bsvs_pkg::bsvs_cmd_type  cmd
);
   import bsvs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POP_WAIT,
      ST_SCAN,
      ST_SWAP_WR1,
      ST_SWAP_WR2
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.kind)
               KIND_PUSH: begin
                  cmd.respond = 1'b1;
                  if (stat.full) begin
                     cmd.rsp_status = STAT_FULL;
                  end else begin
                     cmd.push       = 1'b1;
                     cmd.rsp_status = STAT_OK;
                  end
               end
               KIND_POP: begin
                  if (stat.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STAT_EMPTY;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = ST_POP_WAIT;
                  end
               end
               KIND_SWAP: begin
                  if (stat.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STAT_NOT_FOUND;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = STAT_OK;
               end
            endcase
         end
         ST_POP_WAIT: begin
            cmd.respond    = 1'b1;
            cmd.pop_sel    = 1'b1;
            cmd.rsp_status = STAT_OK;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit_both) begin
               state_in = ST_SWAP_WR1;
            end else if (stat.scan_last) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = STAT_NOT_FOUND;
            end
         end
         ST_SWAP_WR1: begin
            cmd.wr_first = 1'b1;
            state_in     = ST_SWAP_WR2;
         end
         ST_SWAP_WR2: begin
            cmd.wr_second  = 1'b1;
            cmd.respond    = 1'b1;
            cmd.rsp_status = STAT_OK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.respond) begin
         state_in = ST_IDLE;
      end
      rsp_valid_in = cmd.respond;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`include "byte_stack_with_value_swap_assert.svh"

   `BSVS_ASSERT_IMPLY(a_rsp_idle, rsp_valid_ff, state_ff == ST_IDLE, "strobe outside idle")
   `BSVS_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff, "strobe held two cycles")
   `BSVS_ASSERT_NEXT(a_accept_busy, (state_ff == ST_IDLE) && start, busy, "accepted word not taken")

endmodule
